// ===== rtl/core/pcps_pkg.sv =====
// Package for the point-charge potential summation block.
// Holds the sequencer state type and fixed field widths; no dependencies.
`timescale 1ns / 1ps
package pcps_pkg;
	localparam int CoordW = 32;
	localparam int ChargeW = 16;
	localparam int SumW = 48;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQUARE,
		ST_ROOT,
		ST_DIVIDE,
		ST_ACCUM,
		ST_OUTPUT
	} pcps_state_t;
endpackage

// ===== rtl/core/pcps_if.sv =====
// Valid/ready channel interface used by the potential summation block.
// Depends on nothing; payload width is a parameter.
`timescale 1ns / 1ps
interface pcps_if #(parameter int W = 8);
	logic valid;
	logic ready;
	logic [W-1:0] data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== rtl/core/point_charge_potential_sum.sv =====
// Point-charge potential summation: top level.
// Depends on pcps_pkg and pcps_if.
`timescale 1ns / 1ps
// Each accepted item adds -charge/|grid-atom| to a running Q(48-S).S sum;
// an item with last_atom set emits the total and clears the sum. Items are
// worked one at a time by a bit-serial sequencer: three 33-bit squarings
// (shift-and-add), a two-bits-per-cycle square root of the 68-bit sum of
// squares, a rounding step and a restoring divide with one quotient bit per
// cycle, an accumulate step and an output step. The result register parts
// the output from the core: a waiting result holds the core in its output
// state only when the next result is ready to be written and the previous
// one has not been taken.
// Input payload layout: {last_atom, atom_charge, atom_z, atom_y, atom_x,
// grid_z, grid_y, grid_x} with grid_x in the low bits. Output: {saturated,
// potential}.
module point_charge_potential_sum
	import pcps_pkg::*;
#(
	parameter int COORD_FRAC_BITS = 16,
	parameter int SUM_FRAC_BITS = 24
) (
	input logic clk,
	input logic arst_n,
	pcps_if.sink in_ch,
	pcps_if.source out_ch
);
	localparam int DiffW = CoordW + 1;
	localparam int SqW = 2 * DiffW;
	localparam int RootW = DiffW + 1;
	localparam int NumSh = COORD_FRAC_BITS + SUM_FRAC_BITS - 8;
	localparam int QW = 64;

	pcps_state_t state_q, state_d;
	logic [6:0] cnt_q;
	logic [DiffW-1:0] d_q [3];
	logic [1:0] axis_q;
	logic [DiffW-1:0] mplr_q;
	logic [SqW-1:0] prod_q;
	logic [SqW+1:0] sq_q;
	logic [SqW+1:0] rad_q;
	logic [RootW-1:0] root_q;
	logic [RootW+2:0] rem_q;
	logic [QW-1:0] num_q;
	logic [QW-1:0] quo_q;
	logic [RootW+1:0] drem_q;
	logic rnd_q;
	logic [ChargeW-1:0] q_q;
	logic last_q;
	logic signed [SumW-1:0] sum_q;
	logic sat_q;
	logic [SumW:0] res_q;
	logic res_v_q;
	logic out_free;

	// Input unpacking and absolute differences.
	logic signed [DiffW-1:0] df [3];
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			df[i] = $signed({in_ch.data[i*CoordW+CoordW-1],
				in_ch.data[i*CoordW +: CoordW]})
				- $signed({in_ch.data[(i+3)*CoordW+CoordW-1],
				in_ch.data[(i+3)*CoordW +: CoordW]});
			if (df[i][DiffW-1])
				df[i] = -df[i];
		end
	end

	// The result register can take a new result when empty or being read.
	assign out_free = !res_v_q || out_ch.ready;
	assign in_ch.ready = (state_q == ST_IDLE);
	assign out_ch.valid = res_v_q;
	assign out_ch.data = res_q;

	// Root step and divide step datapaths.
	logic [RootW+2:0] rtrial, rshift;
	logic [RootW+1:0] dshift;
	logic [QW-1:0] term;
	logic [SumW:0] room;
	always_comb begin
		rshift = {rem_q[RootW:0], rad_q[SqW+1 -: 2]};
		rtrial = {root_q, 2'b01};
		dshift = {drem_q[RootW:0], num_q[QW-1]};
		term = quo_q;
		room = {sum_q[SumW-1], sum_q} + {1'b0, 1'b1, {(SumW-1){1'b0}}};
	end

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_ch.valid && in_ch.ready) state_d = ST_SQUARE;
			ST_SQUARE: if (cnt_q == 7'(DiffW - 1) && axis_q == 2'd2) state_d = ST_ROOT;
			ST_ROOT: if (cnt_q == 7'(RootW - 1)) state_d = ST_DIVIDE;
			ST_DIVIDE: if (cnt_q == 7'(QW - 1)) state_d = ST_ACCUM;
			ST_ACCUM: state_d = ST_OUTPUT;
			ST_OUTPUT: if (!last_q || out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sum_q <= '0;
			sat_q <= 1'b0;
			res_v_q <= 1'b0;
			cnt_q <= '0;
			axis_q <= '0;
			rnd_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// A new result fills the register; a taken one empties it.
			if (state_q == ST_OUTPUT && last_q && out_free)
				res_v_q <= 1'b1;
			else if (out_ch.valid && out_ch.ready)
				res_v_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					axis_q <= '0;
					if (in_ch.valid && in_ch.ready) begin
						for (int i = 0; i < 3; i++)
							d_q[i] <= DiffW'(df[i]);
						mplr_q <= DiffW'(df[0]);
						prod_q <= '0;
						sq_q <= '0;
						q_q <= in_ch.data[6*CoordW +: ChargeW];
						last_q <= in_ch.data[6*CoordW+ChargeW];
					end
				end
				ST_SQUARE: begin
					// One multiplier bit per cycle, shift-and-add.
					if (cnt_q == 7'(DiffW - 1)) begin
						cnt_q <= '0;
						sq_q <= sq_q + (SqW+2)'(mplr_q[DiffW-1] ?
							{prod_q[SqW-1:0], 1'b0} + SqW'(d_q[axis_q])
							: {prod_q[SqW-1:0], 1'b0});
						prod_q <= '0;
						if (axis_q != 2'd2) begin
							axis_q <= axis_q + 2'd1;
						end else begin
							rem_q <= '0;
							root_q <= '0;
						end
						mplr_q <= d_q[(axis_q == 2'd2) ? 2'd2 : axis_q + 2'd1];
					end else begin
						cnt_q <= cnt_q + 7'd1;
						prod_q <= mplr_q[DiffW-1] ?
							{prod_q[SqW-2:0], 1'b0} + SqW'(d_q[axis_q])
							: {prod_q[SqW-2:0], 1'b0};
						mplr_q <= {mplr_q[DiffW-2:0], 1'b0};
					end
					if (cnt_q == 7'(DiffW - 1) && axis_q == 2'd2)
						rad_q <= sq_q + (SqW+2)'(mplr_q[DiffW-1] ?
							{prod_q[SqW-1:0], 1'b0} + SqW'(d_q[2])
							: {prod_q[SqW-1:0], 1'b0});
				end
				ST_ROOT: begin
					// Two radicand bits per cycle.
					rad_q <= {rad_q[SqW-1:0], 2'b00};
					if (rshift >= rtrial) begin
						rem_q <= rshift - rtrial;
						root_q <= {root_q[RootW-2:0], 1'b1};
					end else begin
						rem_q <= rshift;
						root_q <= {root_q[RootW-2:0], 1'b0};
					end
					cnt_q <= (cnt_q == 7'(RootW - 1)) ? '0 : cnt_q + 7'd1;
					if (cnt_q == 7'(RootW - 1)) begin
						num_q <= (QW'(q_q) << NumSh);
						drem_q <= '0;
						quo_q <= '0;
						rnd_q <= 1'b1;
					end
				end
				ST_DIVIDE: begin
					// Restoring divide, one quotient bit per cycle; a leading
					// step folds in half the divisor for rounding.
					if (rnd_q) begin
						num_q <= num_q + QW'(root_q >> 1);
						rnd_q <= 1'b0;
					end else begin
						num_q <= {num_q[QW-2:0], 1'b0};
						if (dshift >= (RootW+2)'(root_q)) begin
							drem_q <= dshift - (RootW+2)'(root_q);
							quo_q <= {quo_q[QW-2:0], 1'b1};
						end else begin
							drem_q <= dshift;
							quo_q <= {quo_q[QW-2:0], 1'b0};
						end
						cnt_q <= cnt_q + 7'd1;
					end
				end
				ST_ACCUM: begin
					cnt_q <= '0;
					if (root_q == '0 || term > QW'(room)) begin
						sum_q <= {1'b1, {(SumW-1){1'b0}}};
						sat_q <= 1'b1;
					end else begin
						sum_q <= sum_q - SumW'(term);
					end
				end
				ST_OUTPUT: begin
					if (last_q && out_free) begin
						res_q <= {sat_q, sum_q};
						sum_q <= '0;
						sat_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end
endmodule

// ===== tb/tb_point_charge_potential_sum.sv =====
// Testbench for the point-charge potential summation block.
// Depends on pcps_pkg, pcps_if and point_charge_potential_sum.
`timescale 1ns / 1ps
module tb_point_charge_potential_sum;
	import pcps_pkg::*;

	localparam int InW = 6 * CoordW + ChargeW + 1;
	localparam int OutW = SumW + 1;
	localparam int CFrac = 16;
	localparam int SFrac = 24;

	typedef struct packed {
		logic last_atom;
		logic [ChargeW-1:0] charge;
		logic signed [CoordW-1:0] az, ay, ax, gz, gy, gx;
	} atom_item_t;

	typedef struct packed {
		logic saturated;
		logic signed [SumW-1:0] potential;
	} potential_t;

	// Scoreboard: tracks the running sum and queues expected potentials.
	class potential_board;
		logic signed [SumW-1:0] acc;
		bit sat;
		potential_t pending[$];
		int errors;

		function new();
			acc = 0;
			sat = 0;
			errors = 0;
		endfunction

		function automatic logic [33:0] root66(logic [65:0] v);
			logic [33:0] r;
			logic [67:0] rem;
			logic [67:0] trial;
			r = 0;
			rem = 0;
			for (int i = 32; i >= 0; i--) begin
				rem = (rem << 2) | 68'(v[2*i +: 2]);
				trial = (68'(r) << 2) | 68'd1;
				if (rem >= trial) begin
					rem = rem - trial;
					r = (r << 1) | 34'd1;
				end else begin
					r = r << 1;
				end
			end
			return r;
		endfunction

		function automatic logic [32:0] absdiff(logic signed [31:0] g, logic signed [31:0] a);
			logic signed [32:0] d;
			d = 33'(g) - 33'(a);
			return d < 0 ? 33'(-d) : 33'(d);
		endfunction

		function automatic void note_item(atom_item_t it);
			logic [32:0] dx, dy, dz;
			logic [65:0] d2;
			logic [33:0] radius;
			logic [127:0] num, term;
			logic [127:0] room;
			potential_t res;
			dx = 33'(absdiff(it.gx, it.ax));
			dy = 33'(absdiff(it.gy, it.ay));
			dz = 33'(absdiff(it.gz, it.az));
			d2 = 66'(dx) * 66'(dx) + 66'(dy) * 66'(dy) + 66'(dz) * 66'(dz);
			radius = root66(d2);
			// A vanishing distance or an overflowing sum pins the sum to its minimum.
			if (radius == 0) begin
				acc = {1'b1, {(SumW-1){1'b0}}};
				sat = 1;
			end else begin
				num = 128'(it.charge) << (CFrac + SFrac - 8);
				term = (num + 128'(radius >> 1)) / 128'(radius);
				room = 128'($signed(acc) + 49'sh8000_0000_0000) & 128'h1_FFFF_FFFF_FFFF;
				if (term > room) begin
					acc = {1'b1, {(SumW-1){1'b0}}};
					sat = 1;
				end else begin
					acc = acc - SumW'(term);
				end
			end
			if (it.last_atom) begin
				res.potential = acc;
				res.saturated = sat;
				pending.push_back(res);
				acc = 0;
				sat = 0;
			end
		endfunction

		function automatic void check(potential_t got);
			potential_t want;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("Unexpected result: potential %h saturated %0d",
						got.potential, got.saturated);
				return;
			end
			want = pending.pop_front();
			if (got !== want) begin
				errors++;
				if (errors <= 10)
					$display("Mismatch: expected %h/%0d, got %h/%0d", want.potential,
						want.saturated, got.potential, got.saturated);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	pcps_if #(.W(InW)) in_ch ();
	pcps_if #(.W(OutW)) out_ch ();
	potential_board board;
	bit stall_long;
	bit stall_on;

	point_charge_potential_sum DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Check every accepted result.
	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready)
			board.check(potential_t'(out_ch.data));
	end

	// Receiver stalls on a pattern of its own, plus one long hold-off on request.
	always @(posedge clk) begin
		if (stall_long)
			out_ch.ready <= 1'b0;
		else if (stall_on)
			out_ch.ready <= ($urandom_range(0, 3) != 0);
		else
			out_ch.ready <= 1'b1;
	end

	function automatic logic signed [31:0] rand_coord(int mode);
		case (mode)
			0: return $urandom;
			1: return $signed(32'($urandom_range(0, 32'h0010_0000))) - 32'sh0008_0000;
			default: return $signed(32'($urandom_range(0, 32'h0800_0000))) - 32'sh0400_0000;
		endcase
	endfunction

	// Offer one item and hold it until accepted.
	task automatic send_item(atom_item_t it);
		in_ch.valid <= 1'b1;
		in_ch.data <= it;
		do @(posedge clk); while (!in_ch.ready);
		board.note_item(it);
	endtask

	task automatic idle_gap(int n);
		in_ch.valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	function automatic atom_item_t make_item(int mode, bit last);
		atom_item_t it;
		it.gx = rand_coord(mode);
		it.gy = rand_coord(mode);
		it.gz = rand_coord(mode);
		it.ax = rand_coord(mode);
		it.ay = rand_coord(mode);
		it.az = rand_coord(mode);
		it.charge = 16'($urandom);
		it.last_atom = last;
		return it;
	endfunction

	initial begin
		#4_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		atom_item_t it;
		int burst;
		int natoms;
		board = new();
		clk = 1'b0;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		out_ch.ready = 1'b0;
		stall_long = 0;
		stall_on = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extremes of coordinates and charge, coincident points, overflow.
		it = '0;
		it.charge = 16'hFFFF;
		it.last_atom = 1;
		send_item(it);
		it.gx = 32'sh7FFF_FFFF; it.ax = 32'sh8000_0000;
		it.gy = 32'sh7FFF_FFFF; it.ay = 32'sh8000_0000;
		it.gz = 32'sh8000_0000; it.az = 32'sh7FFF_FFFF;
		send_item(it);
		it.charge = 0;
		send_item(it);
		it = '0;
		it.gx = 32'sd1;
		it.charge = 16'hFFFF;
		it.last_atom = 0;
		send_item(it);
		send_item(it);
		it.last_atom = 1;
		send_item(it);
		it = '0;
		it.charge = 0;
		it.last_atom = 1;
		send_item(it);
		it.gx = 32'sh0001_0000;
		it.charge = 16'h0100;
		send_item(it);
		it.gx = -32'sh0001_0000;
		it.gy = 32'sh0000_0003;
		it.ay = 32'shFFFF_FFFF;
		it.charge = 16'h8001;
		it.last_atom = 0;
		send_item(it);
		it.last_atom = 1;
		send_item(it);
		idle_gap(3);

		// Long hold-off while the sender keeps offering.
		stall_long = 1;
		fork
			begin
				repeat (600) @(posedge clk);
				stall_long = 0;
			end
			for (int k = 0; k < 6; k++)
				send_item(make_item(1, 1));
		join
		stall_on = 1;

		// Random sums of a few atoms each, sent in bursts with gaps.
		burst = $urandom_range(1, 8);
		for (int n = 0; n < 530; ) begin
			natoms = $urandom_range(1, 5);
			for (int a = 0; a < natoms; a++) begin
				send_item(make_item($urandom_range(0, 2), a == natoms - 1));
				n++;
				if (--burst == 0) begin
					idle_gap($urandom_range(1, 12));
					burst = $urandom_range(1, 8);
				end
			end
			if (n > 250)
				stall_on = (n % 100) < 70;
		end
		in_ch.valid <= 1'b0;

		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
		if (board.errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule

// ===== sim.f =====
rtl/core/pcps_pkg.sv
rtl/core/pcps_if.sv
rtl/core/point_charge_potential_sum.sv
tb/tb_point_charge_potential_sum.sv
